/* src/vsiu_pkg.sv */
`default_nettype none

package vsiu_pkg;

  localparam logic [7:0] OpPushf = 8'h9c;
  localparam logic [7:0] OpPopf  = 8'h9d;
  localparam logic [7:0] OpIret  = 8'hcf;
  localparam logic [7:0] OpHlt   = 8'hf4;
  localparam logic [7:0] OpCli   = 8'hfa;
  localparam logic [7:0] OpSti   = 8'hfb;

  localparam logic [31:0] FlRes1    = 32'h0000_0002;
  localparam logic [31:0] FlIf      = 32'h0000_0200;
  localparam logic [31:0] FlVm      = 32'h0002_0000;
  localparam logic [31:0] FlAc      = 32'h0004_0000;
  localparam logic [31:0] FlId      = 32'h0020_0000;
  localparam logic [31:0] FlW16     = 32'h0000_7fd5;
  localparam logic [31:0] FlW32     = FlW16 | FlAc | FlId;
  localparam logic [31:0] HighHalf  = 32'hffff_0000;

  typedef enum logic [1:0] {
    CPU_REAL16 = 2'd0,
    CPU_VM86   = 2'd1,
    CPU_OTHER  = 2'd2,
    CPU_RSVD   = 2'd3
  } vsiu_cpu_e;

  typedef enum logic [1:0] {
    MEM_OK       = 2'd0,
    MEM_FAULT    = 2'd1,
    MEM_ROLLBACK = 2'd2,
    MEM_RSVD     = 2'd3
  } vsiu_mem_e;

  typedef enum logic [2:0] {
    ST_EMULATED    = 3'd0,
    ST_HALTED      = 3'd1,
    ST_NOT_HANDLED = 3'd2,
    ST_INVALID     = 3'd3,
    ST_FAULT       = 3'd4,
    ST_ROLLBACK    = 3'd5
  } vsiu_status_e;

  typedef struct packed {
    logic [7:0]  mode;
    logic        operand32;
    vsiu_cpu_e   cpu_kind;
    logic [31:0] cur_ip;
    logic [31:0] cur_sp;
    logic [31:0] cur_flags;
    logic [15:0] cur_cs;
    logic [47:0] stack_data;
    vsiu_mem_e   mem_status;
  } vsiu_item_t;

  typedef struct packed {
    vsiu_status_e status;
    logic [15:0]  new_ip;
    logic [15:0]  new_sp;
    logic [31:0]  new_flags;
    logic [15:0]  new_cs;
    logic         write_enable;
    logic [15:0]  access_offset;
    logic [2:0]   access_bytes;
    logic [31:0]  write_data;
  } vsiu_result_t;

endpackage

`default_nettype wire

/* src/vm86_sensitive_instruction_unit.sv */
// Channel   Handshake            Beat ports
// command   start_i / busy_o     mode_i .. mem_status_i
// result    done_o (strobe)      status_o .. write_data_o
//
// A command beat is registered on the edge it is accepted; its result is
// computed from that register and loaded into the result register on the next
// edge, so it shows on the result ports, with done_o high, for one cycle and is
// taken on the edge that ends that cycle. busy_o stays low, so a command can
// be accepted on every edge. The asynchronous reset clears both valid flags.
// The receiver cannot stall; each result is taken on the edge ending its cycle.

`default_nettype none

module vm86_sensitive_instruction_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [7:0]  mode_i,
  input  wire logic        operand32_i,
  input  wire logic [1:0]  cpu_kind_i,
  input  wire logic [31:0] cur_ip_i,
  input  wire logic [31:0] cur_sp_i,
  input  wire logic [31:0] cur_flags_i,
  input  wire logic [15:0] cur_cs_i,
  input  wire logic [47:0] stack_data_i,
  input  wire logic [1:0]  mem_status_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [15:0]      new_ip_o,
  output logic [15:0]      new_sp_o,
  output logic [31:0]      new_flags_o,
  output logic [15:0]      new_cs_o,
  output logic             write_enable_o,
  output logic [15:0]      access_offset_o,
  output logic [2:0]       access_bytes_o,
  output logic [31:0]      write_data_o
);

  vsiu_pkg::vsiu_item_t   item_d, item_q;
  vsiu_pkg::vsiu_result_t res_d, res_q;
  logic                   vld_q;
  logic                   done_q;
  logic                   accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    item_d.mode       = mode_i;
    item_d.operand32  = operand32_i;
    item_d.cpu_kind   = vsiu_pkg::vsiu_cpu_e'(cpu_kind_i);
    item_d.cur_ip     = cur_ip_i;
    item_d.cur_sp     = cur_sp_i;
    item_d.cur_flags  = cur_flags_i;
    item_d.cur_cs     = cur_cs_i;
    item_d.stack_data = stack_data_i;
    item_d.mem_status = vsiu_pkg::vsiu_mem_e'(mem_status_i);
  end

  vsiu_exec u_exec (
    .item_i   (item_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= accept;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
    if (vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = res_q.status;
  assign new_ip_o        = res_q.new_ip;
  assign new_sp_o        = res_q.new_sp;
  assign new_flags_o     = res_q.new_flags;
  assign new_cs_o        = res_q.new_cs;
  assign write_enable_o  = res_q.write_enable;
  assign access_offset_o = res_q.access_offset;
  assign access_bytes_o  = res_q.access_bytes;
  assign write_data_o    = res_q.write_data;

  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 done_o)
    else $error("accepted command did not produce a result two cycles later");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q |=> !done_o)
    else $error("result strobe without a registered command");

  a_fail_zero_regs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != vsiu_pkg::ST_EMULATED && status_o != vsiu_pkg::ST_HALTED)
    |-> (new_ip_o == 16'd0 && new_sp_o == 16'd0 && new_flags_o == 32'd0 &&
         new_cs_o == 16'd0))
    else $error("failed result carries register values");

  a_write_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && write_enable_o) |-> (access_bytes_o == 3'd2 || access_bytes_o == 3'd4))
    else $error("stack write with a bad size");

  a_invalid_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == vsiu_pkg::ST_INVALID || status_o == vsiu_pkg::ST_NOT_HANDLED))
    |-> (access_bytes_o == 3'd0 && !write_enable_o))
    else $error("stack access requested for an unhandled command");

endmodule

`default_nettype wire

/* src/vsiu_exec.sv */
`default_nettype none

module vsiu_exec (
  input  wire vsiu_pkg::vsiu_item_t item_i,
  output vsiu_pkg::vsiu_result_t    result_o
);

  logic        regs_ok;
  logic        bad_state;
  logic [15:0] ip_next;
  logic [15:0] sp16;
  logic [2:0]  nbytes;
  logic [31:0] pop_mask;
  logic [31:0] pop_word;
  logic [31:0] iret_word;
  logic [15:0] nip;
  logic [15:0] nsp;
  logic [31:0] nfl;
  logic [15:0] ncs;

  assign sp16      = item_i.cur_sp[15:0];
  assign ip_next   = item_i.cur_ip[15:0] + (item_i.operand32 ? 16'd2 : 16'd1);
  assign nbytes    = item_i.operand32 ? 3'd4 : 3'd2;
  assign pop_mask  = item_i.operand32 ? vsiu_pkg::FlW32 : vsiu_pkg::FlW16;
  assign pop_word  = item_i.operand32 ? item_i.stack_data[31:0]
                                      : {16'h0000, item_i.stack_data[15:0]};
  assign iret_word = {16'h0000, item_i.stack_data[47:32]};
  assign bad_state = (item_i.cpu_kind != vsiu_pkg::CPU_REAL16 &&
                      item_i.cpu_kind != vsiu_pkg::CPU_VM86) ||
                     ((item_i.cur_ip & vsiu_pkg::HighHalf) != 32'd0) ||
                     ((item_i.cur_sp & vsiu_pkg::HighHalf) != 32'd0);

  always_comb begin
    result_o        = '0;
    result_o.status = vsiu_pkg::ST_NOT_HANDLED;
    regs_ok         = 1'b0;
    nip             = ip_next;
    nsp             = sp16;
    nfl             = item_i.cur_flags;
    ncs             = item_i.cur_cs;
    if (bad_state) begin
      result_o.status = vsiu_pkg::ST_INVALID;
    end else begin
      case (item_i.mode)
        vsiu_pkg::OpPushf: begin
          result_o.access_bytes  = nbytes;
          result_o.access_offset = sp16 - {13'd0, nbytes};
          result_o.write_enable  = 1'b1;
          result_o.write_data    = item_i.operand32 ?
              ((item_i.cur_flags & ~vsiu_pkg::FlVm) | vsiu_pkg::FlRes1) :
              ({16'h0000, item_i.cur_flags[15:0]} | vsiu_pkg::FlRes1);
          nsp = sp16 - {13'd0, nbytes};
          if (item_i.mem_status == vsiu_pkg::MEM_ROLLBACK) begin
            result_o.status = vsiu_pkg::ST_ROLLBACK;
          end else if (item_i.mem_status != vsiu_pkg::MEM_OK) begin
            result_o.status = vsiu_pkg::ST_FAULT;
          end else begin
            result_o.status = vsiu_pkg::ST_EMULATED;
            regs_ok         = 1'b1;
          end
        end
        vsiu_pkg::OpPopf: begin
          result_o.access_bytes  = nbytes;
          result_o.access_offset = sp16;
          nsp = sp16 + {13'd0, nbytes};
          nfl = (item_i.cur_flags & ~pop_mask) | (pop_word & pop_mask) |
                vsiu_pkg::FlRes1;
          if (item_i.mem_status != vsiu_pkg::MEM_OK) begin
            result_o.status = vsiu_pkg::ST_FAULT;
          end else begin
            result_o.status = vsiu_pkg::ST_EMULATED;
            regs_ok         = 1'b1;
          end
        end
        vsiu_pkg::OpIret: begin
          if (!item_i.operand32) begin
            result_o.access_bytes  = 3'd6;
            result_o.access_offset = sp16;
            nip = item_i.stack_data[15:0];
            ncs = item_i.stack_data[31:16];
            nsp = sp16 + 16'd6;
            nfl = (item_i.cur_flags & ~vsiu_pkg::FlW16) |
                  (iret_word & vsiu_pkg::FlW16) | vsiu_pkg::FlRes1;
            if (item_i.mem_status != vsiu_pkg::MEM_OK) begin
              result_o.status = vsiu_pkg::ST_FAULT;
            end else begin
              result_o.status = vsiu_pkg::ST_EMULATED;
              regs_ok         = 1'b1;
            end
          end
        end
        vsiu_pkg::OpHlt: begin
          result_o.status = vsiu_pkg::ST_HALTED;
          regs_ok         = 1'b1;
        end
        vsiu_pkg::OpCli: begin
          result_o.status = vsiu_pkg::ST_EMULATED;
          regs_ok         = 1'b1;
          nfl             = item_i.cur_flags & ~vsiu_pkg::FlIf;
        end
        vsiu_pkg::OpSti: begin
          result_o.status = vsiu_pkg::ST_EMULATED;
          regs_ok         = 1'b1;
          nfl             = item_i.cur_flags | vsiu_pkg::FlIf;
        end
        default: begin
          result_o.status = vsiu_pkg::ST_NOT_HANDLED;
        end
      endcase
    end
    if (regs_ok) begin
      result_o.new_ip    = nip;
      result_o.new_sp    = nsp;
      result_o.new_flags = nfl;
      result_o.new_cs    = ncs;
    end
  end

endmodule

`default_nettype wire

/* dv/vm86_sensitive_instruction_unit_test.sv */
`timescale 1ns / 1ps

module vm86_sensitive_instruction_unit_test;
  import vsiu_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ResultLatency = 2;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [7:0]  mode_i = '0;
  logic        operand32_i = 1'b0;
  logic [1:0]  cpu_kind_i = '0;
  logic [31:0] cur_ip_i = '0;
  logic [31:0] cur_sp_i = '0;
  logic [31:0] cur_flags_i = '0;
  logic [15:0] cur_cs_i = '0;
  logic [47:0] stack_data_i = '0;
  logic [1:0]  mem_status_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [15:0] new_ip_o;
  logic [15:0] new_sp_o;
  logic [31:0] new_flags_o;
  logic [15:0] new_cs_o;
  logic        write_enable_o;
  logic [15:0] access_offset_o;
  logic [2:0]  access_bytes_o;
  logic [31:0] write_data_o;

  vsiu_result_t outcome_queue[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  burst_left = 0;
  bit           gaps_on = 1'b1;

  vm86_sensitive_instruction_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .mode_i         (mode_i),
    .operand32_i    (operand32_i),
    .cpu_kind_i     (cpu_kind_i),
    .cur_ip_i       (cur_ip_i),
    .cur_sp_i       (cur_sp_i),
    .cur_flags_i    (cur_flags_i),
    .cur_cs_i       (cur_cs_i),
    .stack_data_i   (stack_data_i),
    .mem_status_i   (mem_status_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .new_ip_o       (new_ip_o),
    .new_sp_o       (new_sp_o),
    .new_flags_o    (new_flags_o),
    .new_cs_o       (new_cs_o),
    .write_enable_o (write_enable_o),
    .access_offset_o(access_offset_o),
    .access_bytes_o (access_bytes_o),
    .write_data_o   (write_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("FAIL vm86_sensitive_instruction_unit");
      $finish;
    end
  end

  function automatic vsiu_result_t trap_outcome(vsiu_item_t it);
    vsiu_result_t r;
    logic [15:0]  ip_next;
    logic [31:0]  mask;
    logic [31:0]  popped;
    r = '0;
    r.status = ST_NOT_HANDLED;
    ip_next = it.cur_ip[15:0] + (it.operand32 ? 16'd2 : 16'd1);
    if ((it.cpu_kind != CPU_REAL16 && it.cpu_kind != CPU_VM86) ||
        (it.cur_ip & HighHalf) != '0 || (it.cur_sp & HighHalf) != '0) begin
      r.status = ST_INVALID;
    end else begin
      case (it.mode)
        OpPushf: begin
          r.access_bytes = it.operand32 ? 3'd4 : 3'd2;
          r.access_offset = it.cur_sp[15:0] - 16'(r.access_bytes);
          r.write_enable = 1'b1;
          r.write_data = it.operand32 ? ((it.cur_flags & ~FlVm) | FlRes1)
                                      : ({16'h0, it.cur_flags[15:0]} | FlRes1);
          if (it.mem_status == MEM_ROLLBACK) begin
            r.status = ST_ROLLBACK;
          end else if (it.mem_status != MEM_OK) begin
            r.status = ST_FAULT;
          end else begin
            r.status = ST_EMULATED;
            r.new_ip = ip_next;
            r.new_sp = r.access_offset;
            r.new_flags = it.cur_flags;
            r.new_cs = it.cur_cs;
          end
        end
        OpPopf: begin
          r.access_bytes = it.operand32 ? 3'd4 : 3'd2;
          r.access_offset = it.cur_sp[15:0];
          if (it.mem_status != MEM_OK) begin
            r.status = ST_FAULT;
          end else begin
            mask = it.operand32 ? FlW32 : FlW16;
            popped = it.operand32 ? it.stack_data[31:0] : {16'h0, it.stack_data[15:0]};
            r.status = ST_EMULATED;
            r.new_ip = ip_next;
            r.new_sp = it.cur_sp[15:0] + 16'(r.access_bytes);
            r.new_flags = (it.cur_flags & ~mask) | (popped & mask) | FlRes1;
            r.new_cs = it.cur_cs;
          end
        end
        OpIret: begin
          if (!it.operand32) begin
            r.access_bytes = 3'd6;
            r.access_offset = it.cur_sp[15:0];
            if (it.mem_status != MEM_OK) begin
              r.status = ST_FAULT;
            end else begin
              popped = {16'h0, it.stack_data[47:32]};
              r.status = ST_EMULATED;
              r.new_ip = it.stack_data[15:0];
              r.new_cs = it.stack_data[31:16];
              r.new_flags = (it.cur_flags & ~FlW16) | (popped & FlW16) | FlRes1;
              r.new_sp = it.cur_sp[15:0] + 16'd6;
            end
          end
        end
        OpHlt: begin
          r.status = ST_HALTED;
          r.new_ip = ip_next;
          r.new_sp = it.cur_sp[15:0];
          r.new_flags = it.cur_flags;
          r.new_cs = it.cur_cs;
        end
        OpCli, OpSti: begin
          r.status = ST_EMULATED;
          r.new_ip = ip_next;
          r.new_sp = it.cur_sp[15:0];
          r.new_flags = (it.mode == OpCli) ? (it.cur_flags & ~FlIf) : (it.cur_flags | FlIf);
          r.new_cs = it.cur_cs;
        end
        default: begin
        end
      endcase
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ERROR %s expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Outputs only move after a rising edge, so the value seen at the falling
  // edge is the one taken at the edge that ends the cycle.
  always @(negedge clk_i) begin
    vsiu_result_t want;
    if (rst_ni && done_o !== 1'b0) begin
      if (outcome_queue.size() == 0) begin
        $display("%0t ERROR unexpected result beat expected none actual status %h",
                 $time, status_o);
        mismatch_count++;
      end else begin
        want = outcome_queue.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("new_ip", 32'(want.new_ip), 32'(new_ip_o));
        check_field("new_sp", 32'(want.new_sp), 32'(new_sp_o));
        check_field("new_flags", want.new_flags, new_flags_o);
        check_field("new_cs", 32'(want.new_cs), 32'(new_cs_o));
        check_field("write_enable", 32'(want.write_enable), 32'(write_enable_o));
        check_field("access_offset", 32'(want.access_offset), 32'(access_offset_o));
        check_field("access_bytes", 32'(want.access_bytes), 32'(access_bytes_o));
        check_field("write_data", want.write_data, write_data_o);
      end
    end
  end

  task automatic send_trap(vsiu_item_t it);
    if (gaps_on && burst_left == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    start_i <= 1'b1;
    mode_i <= it.mode;
    operand32_i <= it.operand32;
    cpu_kind_i <= it.cpu_kind;
    cur_ip_i <= it.cur_ip;
    cur_sp_i <= it.cur_sp;
    cur_flags_i <= it.cur_flags;
    cur_cs_i <= it.cur_cs;
    stack_data_i <= it.stack_data;
    mem_status_i <= it.mem_status;
    do @(negedge clk_i); while (busy_o !== 1'b0);
    @(posedge clk_i);
    outcome_queue.push_back(trap_outcome(it));
  endtask

  task automatic wait_for_outstanding();
    start_i <= 1'b0;
    do @(posedge clk_i); while (outcome_queue.size() != 0);
  endtask

  function automatic vsiu_item_t make_trap(logic [7:0] op, logic wide);
    vsiu_item_t it;
    it.mode = op;
    it.operand32 = wide;
    it.cpu_kind = vsiu_cpu_e'($urandom_range(0, 1));
    it.cur_ip = $urandom_range(0, 65535);
    it.cur_sp = $urandom_range(0, 65535);
    it.cur_flags = $urandom;
    it.cur_cs = 16'($urandom);
    it.stack_data = {16'($urandom), 32'($urandom)};
    it.mem_status = MEM_OK;
    return it;
  endfunction

  function automatic vsiu_item_t random_trap();
    vsiu_item_t it;
    logic [7:0] known_ops [6] = '{OpPushf, OpPopf, OpIret, OpHlt, OpCli, OpSti};
    it = make_trap(known_ops[$urandom_range(0, 5)], 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 9) == 0) it.mode = 8'($urandom);
    if ($urandom_range(0, 6) == 0) it.mem_status = vsiu_mem_e'($urandom_range(0, 3));
    case ($urandom_range(0, 19))
      0: it.cpu_kind = vsiu_cpu_e'($urandom_range(2, 3));
      1: it.cur_ip = $urandom;
      2: it.cur_sp = $urandom;
      3: it.cur_ip = 32'h0000_ffff;
      4: it.cur_sp = 32'h0000_ffff - $urandom_range(0, 5);
      5: it.cur_sp = $urandom_range(0, 5);
      default: begin
      end
    endcase
    return it;
  endfunction

  task automatic test_opcodes();
    vsiu_item_t it;
    it = make_trap(OpPushf, 1'b0);
    it.cur_sp = '0;
    it.cur_flags = '1;
    send_trap(it);
    it = make_trap(OpPushf, 1'b1);
    it.cur_sp = 32'd2;
    it.cur_ip = 32'h0000_ffff;
    it.cur_flags = '1;
    send_trap(it);
    it = make_trap(OpPopf, 1'b0);
    it.cur_sp = 32'h0000_ffff;
    it.cur_flags = '0;
    it.stack_data = '1;
    send_trap(it);
    it = make_trap(OpPopf, 1'b1);
    it.cur_sp = 32'h0000_fffe;
    it.cur_flags = '1;
    it.stack_data = '0;
    send_trap(it);
    it = make_trap(OpIret, 1'b0);
    it.cur_sp = 32'h0000_fffc;
    send_trap(it);
    send_trap(make_trap(OpIret, 1'b1));
    it = make_trap(OpHlt, 1'b0);
    it.cur_ip = 32'h0000_ffff;
    send_trap(it);
    it = make_trap(OpCli, 1'b1);
    it.cur_flags = '1;
    send_trap(it);
    it = make_trap(OpSti, 1'b0);
    it.cur_flags = '0;
    send_trap(it);
    send_trap(make_trap('0, 1'b0));
    send_trap(make_trap('1, 1'b1));
  endtask

  task automatic test_invalid_state();
    vsiu_item_t it;
    it = make_trap(OpPushf, 1'b0);
    it.cpu_kind = CPU_OTHER;
    send_trap(it);
    it = make_trap(OpHlt, 1'b0);
    it.cpu_kind = CPU_RSVD;
    send_trap(it);
    it = make_trap(OpCli, 1'b0);
    it.cur_ip = 32'h0001_0000;
    send_trap(it);
    it = make_trap(OpPopf, 1'b1);
    it.cur_sp = 32'hffff_0000;
    send_trap(it);
    it = make_trap(OpIret, 1'b0);
    it.cur_ip = '1;
    it.cur_sp = '1;
    send_trap(it);
  endtask

  task automatic test_memory_outcomes();
    vsiu_item_t it;
    it = make_trap(OpPushf, 1'b0);
    it.mem_status = MEM_FAULT;
    send_trap(it);
    it = make_trap(OpPushf, 1'b1);
    it.mem_status = MEM_ROLLBACK;
    send_trap(it);
    it = make_trap(OpPushf, 1'b1);
    it.mem_status = MEM_RSVD;
    send_trap(it);
    it = make_trap(OpPopf, 1'b0);
    it.mem_status = MEM_ROLLBACK;
    send_trap(it);
    it = make_trap(OpIret, 1'b0);
    it.mem_status = MEM_RSVD;
    send_trap(it);
  endtask

  task automatic test_random_with_gaps(int unsigned count);
    gaps_on = 1'b1;
    repeat (count) send_trap(random_trap());
  endtask

  task automatic test_back_to_back(int unsigned count);
    gaps_on = 1'b0;
    repeat (count) send_trap(random_trap());
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_opcodes();
    test_invalid_state();
    test_memory_outcomes();
    wait_for_outstanding();
    test_random_with_gaps(300);
    test_back_to_back(150);
    wait_for_outstanding();
    test_random_with_gaps(200);
    wait_for_outstanding();
    repeat (ResultLatency + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS vm86_sensitive_instruction_unit");
    end else begin
      $display("FAIL vm86_sensitive_instruction_unit");
    end
    $finish;
  end

endmodule
